[rtl/ibvg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibvg_pkg
// Shared widths, codes, constants and helper functions of the inlet boundary
// velocity generator.
// ----------------------------------------------------------------------------
package ibvg_pkg;

  // Field widths.
  localparam int unsigned IdxW  = 10;
  localparam int unsigned DimW  = 11;
  localparam int unsigned AddrW = 20;
  localparam int unsigned DataW = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned RegW  = 3;

  // Grid dimensions above this are clamped.
  localparam int unsigned MaxDim = 1024;

  // Default number of rotation steps.
  localparam int unsigned CordicSteps = 16;

  // Q16.16 angle constants and the Q2.30 rotation gain.
  localparam int TwoPiQ16      = 411775;
  localparam int PiQ16         = 205887;
  localparam int HalfPiQ16     = 102944;
  localparam int CordicGainQ30 = 652032874;

  // Edge codes.
  localparam logic [1:0] EDGE_LEFT   = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_TOP    = 2'd3;

  // Base velocity modes.
  localparam logic [1:0] SPEC_COMP = 2'd0;
  localparam logic [1:0] SPEC_MAG  = 2'd1;
  localparam logic [1:0] SPEC_MASS = 2'd2;
  localparam logic [1:0] SPEC_ZERO = 2'd3;

  // Profile modes.
  localparam logic [1:0] PROF_UNIFORM = 2'd0;
  localparam logic [1:0] PROF_PARAB   = 2'd1;
  localparam logic [1:0] PROF_CUSTOM  = 2'd2;

  // Status codes.
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_SMALL = 2'd1;
  localparam logic [StatW-1:0] STAT_PAST  = 2'd2;
  localparam logic [StatW-1:0] STAT_ZDIV  = 2'd3;

  // Register indexes.
  localparam logic [RegW-1:0] REG_EDGE    = 3'd0;
  localparam logic [RegW-1:0] REG_WIDTH   = 3'd1;
  localparam logic [RegW-1:0] REG_HEIGHT  = 3'd2;
  localparam logic [RegW-1:0] REG_SPEC    = 3'd3;
  localparam logic [RegW-1:0] REG_PROFILE = 3'd4;
  localparam logic [RegW-1:0] REG_PARAM_A = 3'd5;
  localparam logic [RegW-1:0] REG_PARAM_B = 3'd6;
  localparam logic [RegW-1:0] REG_PARAM_C = 3'd7;

  // Arctangent of 2^-i in Q16.16.
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:    r = 17'd51472;
      5'd1:    r = 17'd30386;
      5'd2:    r = 17'd16055;
      5'd3:    r = 17'd8150;
      5'd4:    r = 17'd4091;
      5'd5:    r = 17'd2047;
      5'd6:    r = 17'd1024;
      5'd7:    r = 17'd512;
      5'd8:    r = 17'd256;
      5'd9:    r = 17'd128;
      5'd10:   r = 17'd64;
      5'd11:   r = 17'd32;
      5'd12:   r = 17'd16;
      5'd13:   r = 17'd8;
      5'd14:   r = 17'd4;
      5'd15:   r = 17'd2;
      5'd16:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/ibvg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibvg channel interfaces
// Valid/ready channels for point index words and boundary cell words.
// ----------------------------------------------------------------------------
interface ibvg_in_if;
  logic                          valid;
  logic                          ready;
  logic [ibvg_pkg::IdxW-1:0]     point_index;

  modport source(output valid, output point_index, input ready);
  modport sink(input valid, input point_index, output ready);
endinterface

interface ibvg_out_if;
  logic                          valid;
  logic                          ready;
  logic [ibvg_pkg::AddrW-1:0]    cell_address;
  logic signed [ibvg_pkg::DataW-1:0] u_velocity;
  logic signed [ibvg_pkg::DataW-1:0] v_velocity;
  logic [ibvg_pkg::StatW-1:0]    status;

  modport source(output valid, output cell_address, output u_velocity,
                 output v_velocity, output status, input ready);
  modport sink(input valid, input cell_address, input u_velocity,
               input v_velocity, input status, output ready);
endinterface

[rtl/inlet_boundary_velocity_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inlet_boundary_velocity_generator_core
// Maps a point index on the chosen grid edge to its cell address and its
// inlet velocity pair, with a uniform or parabolic profile.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  in_ch   | in  | point_index
//  out_ch  | out | cell_address, u_velocity, v_velocity, status
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// One word enters per cycle while in_ch.ready is high; the stages are input,
// address, 17 stages of the profile divider, multiply and output register.
// The base velocity depends on the registers only and is worked out by a
// sequencer after reset and after each register write: given components are
// copied, magnitude and angle take a reduction and 16 rotation steps by
// default, mass flow a 48-step divider. in_ch.ready is low then.
// A stall holds each stage that cannot move on; empty stages still fill.
// ----------------------------------------------------------------------------
module inlet_boundary_velocity_generator_core #(
  parameter int unsigned CORDIC_STEPS = ibvg_pkg::CordicSteps
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ibvg_in_if.sink                     in_ch,
  ibvg_out_if.source                  out_ch,
  input  logic                        cfg_we_i,
  input  logic [ibvg_pkg::RegW-1:0]   cfg_idx_i,
  input  logic [ibvg_pkg::DataW-1:0]  cfg_data_i
);

  localparam int unsigned NumStg  = 21;
  localparam int unsigned DivStg  = 17;
  localparam int unsigned MulStg  = 19;
  localparam int unsigned OutStg  = 20;
  localparam logic [5:0]  RotLast = 6'(CORDIC_STEPS - 1);
  localparam logic [5:0]  RedLast = 6'd13;
  localparam logic [5:0]  DivLast = 6'd47;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_START, SQ_RED, SQ_ANG, SQ_ROT, SQ_MULC, SQ_MULS, SQ_SATS,
    SQ_DDEN, SQ_DDIV, SQ_DFIN
  } seq_e;

  // Configuration registers.
  logic [1:0]         edge_q, spec_q, prof_q;
  logic [10:0]        gw_q, gh_q;
  logic signed [31:0] pa_q, pb_q, pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= ibvg_pkg::EDGE_LEFT;
      gw_q   <= 11'd3;
      gh_q   <= 11'd3;
      spec_q <= ibvg_pkg::SPEC_COMP;
      prof_q <= ibvg_pkg::PROF_UNIFORM;
      pa_q   <= 32'sd0;
      pb_q   <= 32'sd0;
      pc_q   <= 32'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ibvg_pkg::REG_EDGE:    edge_q <= cfg_data_i[1:0];
        ibvg_pkg::REG_WIDTH:   gw_q   <= cfg_data_i[10:0];
        ibvg_pkg::REG_HEIGHT:  gh_q   <= cfg_data_i[10:0];
        ibvg_pkg::REG_SPEC:    spec_q <= cfg_data_i[1:0];
        ibvg_pkg::REG_PROFILE: prof_q <= cfg_data_i[1:0];
        ibvg_pkg::REG_PARAM_A: pa_q   <= cfg_data_i;
        ibvg_pkg::REG_PARAM_B: pb_q   <= cfg_data_i;
        ibvg_pkg::REG_PARAM_C: pc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped grid and edge geometry.
  logic [10:0] w_c, h_c, len_c;
  logic [9:0]  d_c;
  logic        small_c;

  always_comb begin
    w_c     = (gw_q > 11'(ibvg_pkg::MaxDim)) ? 11'(ibvg_pkg::MaxDim) : gw_q;
    h_c     = (gh_q > 11'(ibvg_pkg::MaxDim)) ? 11'(ibvg_pkg::MaxDim) : gh_q;
    len_c   = (edge_q == ibvg_pkg::EDGE_LEFT || edge_q == ibvg_pkg::EDGE_RIGHT)
              ? h_c : w_c;
    d_c     = 10'(len_c - 11'd1);
    small_c = (w_c < 11'd3) || (h_c < 11'd3);
  end

  // Geometry terms that follow the registers in the next cycle.
  logic [19:0] dd_q, top_q;
  logic [10:0] wm1_q;

  always_ff @(posedge clk_i) begin
    dd_q  <= 20'(d_c) * 20'(d_c);
    top_q <= 20'(22'(h_c - 11'd1) * 22'(w_c));
    wm1_q <= w_c - 11'd1;
  end

  // Base velocity sequencer.
  seq_e               st_q;
  logic [5:0]         cnt_q;
  logic signed [31:0] ub_q, vb_q;
  logic               zdiv_q;
  logic [31:0]        red_q;
  logic               aneg_q, flip_q, qneg_q;
  logic signed [19:0] t_q;
  logic signed [33:0] x_q, y_q;
  logic signed [63:0] prod_q;
  logic [46:0]        dsr_q;
  logic [47:0]        rem_q, dvd_q;

  logic [31:0]        bmag, amag, red_sub;
  logic               red_ge;
  logic [18:0]        t0;
  logic signed [20:0] ta, tb;
  logic               tflip;
  logic [4:0]         sh;
  logic signed [33:0] xs, ys, cx, cy;
  logic signed [19:0] at;
  logic signed [63:0] rnd30, pmag;
  logic [46:0]        dmag;
  logic [48:0]        r2;
  logic               dge;
  logic signed [48:0] qs;
  logic signed [31:0] avg, navg;

  always_comb begin
    bmag    = pb_q[31] ? 32'(-pb_q) : pb_q;
    amag    = pa_q[31] ? 32'(-pa_q) : pa_q;
    red_sub = 32'(ibvg_pkg::TwoPiQ16) << (4'(RedLast - cnt_q));
    red_ge  = red_q >= red_sub;
    // Fold the remainder into [-pi, pi], then into [-pi/2, pi/2].
    t0 = (aneg_q && red_q != 32'd0) ? 19'(32'(ibvg_pkg::TwoPiQ16) - red_q)
                                    : red_q[18:0];
    ta = $signed({2'b00, t0});
    if (ta > 21'(ibvg_pkg::PiQ16)) begin
      ta = ta - 21'(ibvg_pkg::TwoPiQ16);
    end
    tb    = ta;
    tflip = 1'b0;
    if (ta > 21'(ibvg_pkg::HalfPiQ16)) begin
      tb    = ta - 21'(ibvg_pkg::PiQ16);
      tflip = 1'b1;
    end else if (ta < -21'(ibvg_pkg::HalfPiQ16)) begin
      tb    = ta + 21'(ibvg_pkg::PiQ16);
      tflip = 1'b1;
    end
    // One rotation step.
    sh = cnt_q[4:0];
    xs = x_q >>> sh;
    ys = y_q >>> sh;
    at = $signed({3'b000, ibvg_pkg::atan_q16(sh)});
    cx = flip_q ? -x_q : x_q;
    cy = flip_q ? -y_q : y_q;
    rnd30 = (prod_q + 64'sd536870912) >>> 30;
    // Mass flow divisor, truncated toward zero.
    pmag = prod_q[63] ? -prod_q : prod_q;
    dmag = pmag[62:16];
    // One restoring divide step.
    r2  = {rem_q, dvd_q[47]};
    dge = r2 >= {2'b00, dsr_q};
    qs   = qneg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
    avg  = ibvg_pkg::sat32(64'(qs));
    navg = ibvg_pkg::sat32(-64'(avg));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SQ_START;
      cnt_q  <= 6'd0;
      ub_q   <= 32'sd0;
      vb_q   <= 32'sd0;
      zdiv_q <= 1'b0;
    end else if (cfg_we_i) begin
      st_q <= SQ_START;
    end else begin
      case (st_q)
        SQ_START: begin
          zdiv_q <= 1'b0;
          cnt_q  <= 6'd0;
          case (spec_q)
            ibvg_pkg::SPEC_COMP: begin
              ub_q <= pa_q;
              vb_q <= pb_q;
              st_q <= SQ_IDLE;
            end
            ibvg_pkg::SPEC_MAG: begin
              red_q  <= bmag;
              aneg_q <= pb_q[31];
              st_q   <= SQ_RED;
            end
            ibvg_pkg::SPEC_MASS: begin
              prod_q <= pb_q * pc_q;
              st_q   <= SQ_DDEN;
            end
            default: begin
              ub_q <= 32'sd0;
              vb_q <= 32'sd0;
              st_q <= SQ_IDLE;
            end
          endcase
        end
        SQ_RED: begin
          if (red_ge) begin
            red_q <= red_q - red_sub;
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == RedLast) begin
            st_q <= SQ_ANG;
          end
        end
        SQ_ANG: begin
          t_q    <= tb[19:0];
          flip_q <= tflip;
          x_q    <= 34'(ibvg_pkg::CordicGainQ30);
          y_q    <= 34'sd0;
          cnt_q  <= 6'd0;
          st_q   <= SQ_ROT;
        end
        SQ_ROT: begin
          if (!t_q[19]) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            t_q <= t_q - at;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            t_q <= t_q + at;
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == RotLast) begin
            st_q <= SQ_MULC;
          end
        end
        SQ_MULC: begin
          prod_q <= pa_q * $signed(cx[31:0]);
          st_q   <= SQ_MULS;
        end
        SQ_MULS: begin
          ub_q   <= ibvg_pkg::sat32(rnd30);
          prod_q <= pa_q * $signed(cy[31:0]);
          st_q   <= SQ_SATS;
        end
        SQ_SATS: begin
          vb_q <= ibvg_pkg::sat32(rnd30);
          st_q <= SQ_IDLE;
        end
        SQ_DDEN: begin
          if (dmag == 47'd0) begin
            zdiv_q <= 1'b1;
            ub_q   <= 32'sd0;
            vb_q   <= 32'sd0;
            st_q   <= SQ_IDLE;
          end else begin
            dsr_q  <= dmag;
            dvd_q  <= {amag, 16'h0000};
            rem_q  <= 48'd0;
            qneg_q <= pa_q[31] ^ prod_q[63];
            cnt_q  <= 6'd0;
            st_q   <= SQ_DDIV;
          end
        end
        SQ_DDIV: begin
          rem_q <= dge ? 48'(r2 - {2'b00, dsr_q}) : r2[47:0];
          dvd_q <= {dvd_q[46:0], dge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == DivLast) begin
            st_q <= SQ_DFIN;
          end
        end
        SQ_DFIN: begin
          // The mean speed points into the domain from the chosen edge.
          case (edge_q)
            ibvg_pkg::EDGE_LEFT: begin
              ub_q <= avg;
              vb_q <= 32'sd0;
            end
            ibvg_pkg::EDGE_RIGHT: begin
              ub_q <= navg;
              vb_q <= 32'sd0;
            end
            ibvg_pkg::EDGE_BOTTOM: begin
              ub_q <= 32'sd0;
              vb_q <= avg;
            end
            default: begin
              ub_q <= 32'sd0;
              vb_q <= navg;
            end
          endcase
          st_q <= SQ_IDLE;
        end
        default: st_q <= SQ_IDLE;
      endcase
    end
  end

  // Stage handshake: a stage moves on when it is empty or the next one moves.
  logic [NumStg-1:0] vld_q, adv;
  logic              in_acc;

  always_comb begin
    adv[NumStg-1] = !vld_q[NumStg-1] || out_ch.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0] && (st_q == SQ_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_acc;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Address, status and profile numerator from the index.
  logic [9:0]  s0_idx_q;
  logic        past;
  logic [20:0] iw;
  logic [9:0]  dmi;
  logic [19:0] pq, addr_c;
  logic [1:0]  stat_c;

  always_comb begin
    past = {1'b0, s0_idx_q} >= len_c;
    iw   = 21'(s0_idx_q) * 21'(w_c);
    dmi  = d_c - s0_idx_q;
    pq   = 20'(dmi) * 20'(s0_idx_q);
    case (edge_q)
      ibvg_pkg::EDGE_LEFT:   addr_c = iw[19:0];
      ibvg_pkg::EDGE_RIGHT:  addr_c = iw[19:0] + 20'(wm1_q);
      ibvg_pkg::EDGE_BOTTOM: addr_c = 20'(s0_idx_q);
      default:               addr_c = top_q + 20'(s0_idx_q);
    endcase
    if (small_c) begin
      stat_c = ibvg_pkg::STAT_SMALL;
    end else if (past) begin
      stat_c = ibvg_pkg::STAT_PAST;
    end else if (zdiv_q) begin
      stat_c = ibvg_pkg::STAT_ZDIV;
    end else begin
      stat_c = ibvg_pkg::STAT_OK;
    end
  end

  logic [19:0] s1_addr_q, s1_q4_q;
  logic [1:0]  s1_stat_q;
  logic        s1_par_q;
  logic [36:0] n0;

  assign n0 = 37'({s1_q4_q, 16'h0000}) + 37'(dd_q[19:1]);

  // Profile factor divider, one quotient bit per stage.
  logic [19:0] dv_r_q [DivStg];
  logic [16:0] dv_n_q [DivStg];
  logic [16:0] dv_f_q [DivStg];
  logic [19:0] dv_a_q [DivStg];
  logic [1:0]  dv_s_q [DivStg];
  logic        dv_p_q [DivStg];
  logic [19:0] dv_r_d [DivStg];
  logic [16:0] dv_n_d [DivStg];
  logic [16:0] dv_f_d [DivStg];
  logic [19:0] dv_a_d [DivStg];
  logic [1:0]  dv_s_d [DivStg];
  logic        dv_p_d [DivStg];

  always_comb begin
    for (int j = 0; j < DivStg; j++) begin
      logic [19:0] rin;
      logic [16:0] nin, fin;
      logic [20:0] rr;
      logic        ge;
      if (j == 0) begin
        rin       = n0[36:17];
        nin       = n0[16:0];
        fin       = 17'd0;
        dv_a_d[j] = s1_addr_q;
        dv_s_d[j] = s1_stat_q;
        dv_p_d[j] = s1_par_q;
      end else begin
        rin       = dv_r_q[j-1];
        nin       = dv_n_q[j-1];
        fin       = dv_f_q[j-1];
        dv_a_d[j] = dv_a_q[j-1];
        dv_s_d[j] = dv_s_q[j-1];
        dv_p_d[j] = dv_p_q[j-1];
      end
      rr        = {rin, nin[DivStg-1-j]};
      ge        = rr >= {1'b0, dd_q};
      dv_r_d[j] = ge ? 20'(rr - {1'b0, dd_q}) : rr[19:0];
      dv_n_d[j] = nin;
      dv_f_d[j] = {fin[15:0], ge};
    end
  end

  // Multiply and output stage words.
  logic [19:0]        m_addr_q;
  logic [1:0]         m_stat_q;
  logic               m_par_q;
  logic signed [49:0] m_pu_q, m_pv_q;
  logic signed [50:0] ru, rv;
  logic [19:0]        o_addr_q;
  logic [1:0]         o_stat_q;
  logic signed [31:0] o_u_q, o_v_q, u_c, v_c;

  always_comb begin
    ru = (51'(m_pu_q) + 51'sd32768) >>> 16;
    rv = (51'(m_pv_q) + 51'sd32768) >>> 16;
    if (m_stat_q != ibvg_pkg::STAT_OK) begin
      u_c = 32'sd0;
      v_c = 32'sd0;
    end else if (m_par_q) begin
      u_c = ibvg_pkg::sat32(64'(ru));
      v_c = ibvg_pkg::sat32(64'(rv));
    end else begin
      u_c = ub_q;
      v_c = vb_q;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_idx_q <= in_ch.point_index;
    end
    if (adv[1]) begin
      s1_addr_q <= (small_c || past) ? 20'd0 : addr_c;
      s1_stat_q <= stat_c;
      s1_q4_q   <= {pq[17:0], 2'b00};
      s1_par_q  <= (prof_q == ibvg_pkg::PROF_PARAB);
    end
    for (int j = 0; j < DivStg; j++) begin
      if (adv[2+j]) begin
        dv_r_q[j] <= dv_r_d[j];
        dv_n_q[j] <= dv_n_d[j];
        dv_f_q[j] <= dv_f_d[j];
        dv_a_q[j] <= dv_a_d[j];
        dv_s_q[j] <= dv_s_d[j];
        dv_p_q[j] <= dv_p_d[j];
      end
    end
    if (adv[MulStg]) begin
      m_addr_q <= dv_a_q[DivStg-1];
      m_stat_q <= dv_s_q[DivStg-1];
      m_par_q  <= dv_p_q[DivStg-1];
      m_pu_q   <= ub_q * $signed({1'b0, dv_f_q[DivStg-1]});
      m_pv_q   <= vb_q * $signed({1'b0, dv_f_q[DivStg-1]});
    end
    if (adv[OutStg]) begin
      o_addr_q <= m_addr_q;
      o_stat_q <= m_stat_q;
      o_u_q    <= u_c;
      o_v_q    <= v_c;
    end
  end

  assign out_ch.valid        = vld_q[OutStg];
  assign out_ch.cell_address = o_addr_q;
  assign out_ch.u_velocity   = o_u_q;
  assign out_ch.v_velocity   = o_v_q;
  assign out_ch.status       = o_stat_q;

endmodule
